@@ hw/rtl/las_pkg.sv @@
package las_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int SUM_W     = SQ_W + 1;
    localparam int DIST_FRAC = 8;
    localparam int TRIG_FRAC = 16;
    localparam int TRIG_W    = 16;
    localparam int TAN_W     = 18;
    localparam int CMP_W     = COORD_W + TAN_W;
    localparam int ROOT_W    = (SUM_W + 2 * DIST_FRAC + 1) / 2;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 2;
    localparam int PROD_W    = ROOT_W + TRIG_W;
    localparam int RND_SH    = TRIG_FRAC + DIST_FRAC;
    localparam int MAG_W     = PROD_W - RND_SH + 1;
    localparam int EXT_W     = ((MAG_W > COORD_W) ? MAG_W : COORD_W) + 2;

    // Q2.16 tangents of the half-way angles
    localparam int TAN_N = 7;
    localparam int TI_15 = 0;
    localparam int TI_22 = 1;
    localparam int TI_37 = 2;
    localparam int TI_45 = 3;
    localparam int TI_52 = 4;
    localparam int TI_67 = 5;
    localparam int TI_75 = 6;
    localparam logic [TAN_W-1:0] TAN_TAB [TAN_N] = '{
        18'd17560, 18'd27146, 18'd50288, 18'd65536, 18'd85408, 18'd158218, 18'd244584
    };

    // Q0.16 cos/sin values
    localparam logic [TRIG_W-1:0] TRIG_HALF  = 16'd32768;
    localparam logic [TRIG_W-1:0] TRIG_COS30 = 16'd56756;
    localparam logic [TRIG_W-1:0] TRIG_DIAG  = 16'd46341;

    typedef enum logic [2:0] {
        ANG_0    = 3'd0,
        ANG_30   = 3'd1,
        ANG_45   = 3'd2,
        ANG_60   = 3'd3,
        ANG_90   = 3'd4,
        ANG_NONE = 3'd5
    } t_angle;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] rx;
        logic signed [COORD_W-1:0] ry;
        logic                      negx;
        logic                      negy;
        t_angle                    code;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [RAD_W-1:0]  rad;
    } t_fwd;

    typedef struct packed {
        t_side             side;
        logic [ROOT_W-1:0] len;
    } t_dist;

endpackage

@@ hw/rtl/las_if.sv @@
interface las_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [las_pkg::COORD_W-1:0] start_x;
    logic signed [las_pkg::COORD_W-1:0] start_y;
    logic signed [las_pkg::COORD_W-1:0] end_x;
    logic signed [las_pkg::COORD_W-1:0] end_y;
    logic                               snap_45;
    logic                               snap_30_60;

    modport source (output valid, start_x, start_y, end_x, end_y, snap_45, snap_30_60,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, snap_45, snap_30_60,
                    output ready);
endinterface

interface las_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [las_pkg::COORD_W-1:0] snapped_x;
    logic signed [las_pkg::COORD_W-1:0] snapped_y;
    logic [2:0]                         angle_code;
    logic                               clipped;

    modport source (output valid, snapped_x, snapped_y, angle_code, clipped, input ready);
    modport sink   (input valid, snapped_x, snapped_y, angle_code, clipped, output ready);
endinterface

@@ hw/rtl/las_front.sv @@
module las_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    las_in_if.sink        i_in,
    output logic          o_valid,
    output las_pkg::t_fwd o_data,
    input  logic          i_ready
);

    localparam int W  = las_pkg::COORD_W;
    localparam int DW = las_pkg::DIFF_W;
    localparam int CW = las_pkg::CMP_W;

    logic en1, en2, en3, en4;

    // stage 1: differences
    logic                 r1_v;
    logic signed [W-1:0]  r1_sx, r1_sy, r1_ex, r1_ey;
    logic signed [DW-1:0] r1_dx, r1_dy;
    logic [1:0]           r1_snap;
    logic signed [DW-1:0] n1_dx, n1_dy;

    // stage 2: magnitudes and squares
    logic                          r2_v;
    logic signed [W-1:0]           r2_sx, r2_sy, r2_ex, r2_ey;
    logic [1:0]                    r2_snap;
    logic                          r2_negx, r2_negy;
    logic [W-1:0]                  r2_adx, r2_ady;
    logic [las_pkg::SQ_W-1:0]      r2_sqx, r2_sqy;
    logic [DW-1:0]                 n2_absx, n2_absy;
    logic [W-1:0]                  n2_adx, n2_ady;

    // stage 3: threshold products and distance squared
    logic                          r3_v;
    logic signed [W-1:0]           r3_sx, r3_sy, r3_ex, r3_ey;
    logic [1:0]                    r3_snap;
    logic                          r3_negx, r3_negy;
    logic [CW-1:0]                 r3_tp [las_pkg::TAN_N];
    logic [CW-1:0]                 r3_ady_sh;
    logic [las_pkg::SUM_W-1:0]     r3_sum;

    // stage 4: angle decision
    logic                          r4_v;
    las_pkg::t_fwd                 r4_data;
    logic [las_pkg::TAN_N-1:0]     lt;
    las_pkg::t_angle               n4_code;
    logic signed [W-1:0]           n4_rx, n4_ry;

    assign en4 = !r4_v || i_ready;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_in.ready = en1;
    assign o_valid = r4_v;
    assign o_data  = r4_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_in.valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    assign n1_dx = DW'(i_in.end_x) - DW'(i_in.start_x);
    assign n1_dy = DW'(i_in.end_y) - DW'(i_in.start_y);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_sx   <= i_in.start_x;
            r1_sy   <= i_in.start_y;
            r1_ex   <= i_in.end_x;
            r1_ey   <= i_in.end_y;
            r1_dx   <= n1_dx;
            r1_dy   <= n1_dy;
            r1_snap <= {i_in.snap_30_60, i_in.snap_45};
        end
    end

    assign n2_absx = r1_dx[DW-1] ? DW'(-r1_dx) : DW'(r1_dx);
    assign n2_absy = r1_dy[DW-1] ? DW'(-r1_dy) : DW'(r1_dy);
    assign n2_adx  = n2_absx[W-1:0];
    assign n2_ady  = n2_absy[W-1:0];

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_ex   <= r1_ex;
            r2_ey   <= r1_ey;
            r2_snap <= r1_snap;
            r2_negx <= r1_dx[DW-1];
            r2_negy <= r1_dy[DW-1];
            r2_adx  <= n2_adx;
            r2_ady  <= n2_ady;
            r2_sqx  <= las_pkg::SQ_W'(n2_adx) * las_pkg::SQ_W'(n2_adx);
            r2_sqy  <= las_pkg::SQ_W'(n2_ady) * las_pkg::SQ_W'(n2_ady);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_sx     <= r2_sx;
            r3_sy     <= r2_sy;
            r3_ex     <= r2_ex;
            r3_ey     <= r2_ey;
            r3_snap   <= r2_snap;
            r3_negx   <= r2_negx;
            r3_negy   <= r2_negy;
            r3_ady_sh <= CW'(r2_ady) << las_pkg::TRIG_FRAC;
            r3_sum    <= las_pkg::SUM_W'(r2_sqx) + las_pkg::SUM_W'(r2_sqy);
            for (int k = 0; k < las_pkg::TAN_N; k++) begin
                r3_tp[k] <= CW'(r2_adx) * CW'(las_pkg::TAN_TAB[k]);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < las_pkg::TAN_N; k++) begin
            lt[k] = r3_ady_sh < r3_tp[k];
        end
    end

    // snap bits are {30/60, 45}; the lowest threshold passed picks the angle
    always_comb begin
        n4_code = las_pkg::ANG_NONE;
        unique case (r3_snap)
            2'b00: n4_code = las_pkg::ANG_NONE;
            2'b01: begin
                if (lt[las_pkg::TI_22])      n4_code = las_pkg::ANG_0;
                else if (lt[las_pkg::TI_67]) n4_code = las_pkg::ANG_45;
                else                         n4_code = las_pkg::ANG_90;
            end
            2'b10: begin
                if (lt[las_pkg::TI_15])      n4_code = las_pkg::ANG_0;
                else if (lt[las_pkg::TI_45]) n4_code = las_pkg::ANG_30;
                else if (lt[las_pkg::TI_75]) n4_code = las_pkg::ANG_60;
                else                         n4_code = las_pkg::ANG_90;
            end
            2'b11: begin
                if (lt[las_pkg::TI_15])      n4_code = las_pkg::ANG_0;
                else if (lt[las_pkg::TI_37]) n4_code = las_pkg::ANG_30;
                else if (lt[las_pkg::TI_52]) n4_code = las_pkg::ANG_45;
                else if (lt[las_pkg::TI_75]) n4_code = las_pkg::ANG_60;
                else                         n4_code = las_pkg::ANG_90;
            end
            default: n4_code = las_pkg::ANG_NONE;
        endcase
    end

    always_comb begin
        n4_rx = r3_ex;
        n4_ry = r3_ey;
        case (n4_code)
            las_pkg::ANG_0:  n4_ry = r3_sy;
            las_pkg::ANG_90: n4_rx = r3_sx;
            default: begin
                n4_rx = r3_ex;
                n4_ry = r3_ey;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_data.side.sx   <= r3_sx;
            r4_data.side.sy   <= r3_sy;
            r4_data.side.rx   <= n4_rx;
            r4_data.side.ry   <= n4_ry;
            r4_data.side.negx <= r3_negx;
            r4_data.side.negy <= r3_negy;
            r4_data.side.code <= n4_code;
            r4_data.rad       <= las_pkg::RAD_W'(r3_sum) << (2 * las_pkg::DIST_FRAC);
        end
    end

    // a vertical or degenerate line lands on 90 degrees whenever a snap flag is set
    a_zero_dx_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r3_v && en4 && r3_tp[las_pkg::TI_15] == '0 && r3_snap != 2'b00)
        |=> (r4_data.side.code == las_pkg::ANG_90))
        else $error("zero dx did not snap to 90 degrees");

endmodule

@@ hw/rtl/las_sqrt.sv @@
module las_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  las_pkg::t_fwd  i_data,
    output logic           o_ready,
    output logic           o_valid,
    output las_pkg::t_dist o_data,
    input  logic           i_ready
);

    localparam int RW = las_pkg::ROOT_W;
    localparam int MW = las_pkg::REM_W;
    localparam int AW = las_pkg::RAD_W;
    localparam int L  = RW - 1;

    // one root bit per stage, restoring digit recurrence
    logic               r_v    [RW];
    las_pkg::t_side     r_side [RW];
    logic [AW-1:0]      r_rad  [RW];
    logic [MW-1:0]      r_rem  [RW];
    logic [RW-1:0]      r_root [RW];
    logic               en     [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int BI = RW - 1 - s;

        logic               v_in;
        las_pkg::t_side     side_in;
        logic [AW-1:0]      rad_in;
        logic [MW-1:0]      rem_in;
        logic [RW-1:0]      root_in;
        logic [MW-1:0]      rem_sh, trial, n_rem;
        logic [RW-1:0]      n_root;

        if (s == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_data.side;
            assign rad_in  = i_data.rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[s-1];
            assign side_in = r_side[s-1];
            assign rad_in  = r_rad[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
        end

        if (s == L) begin : g_last_en
            assign en[s] = !r_v[s] || i_ready;
        end else begin : g_mid_en
            assign en[s] = !r_v[s] || en[s+1];
        end

        assign rem_sh = {rem_in[MW-3:0], rad_in[2*BI+1 -: 2]};
        assign trial  = {root_in, 2'b01};

        always_comb begin
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {root_in[RW-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {root_in[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en[s]) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_side[s] <= side_in;
                r_rad[s]  <= rad_in;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_ready     = en[0];
    assign o_valid     = r_v[L];
    assign o_data.side = r_side[L];
    assign o_data.len  = r_root[L];

    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[L] && !i_ready) |=> (r_v[L] && $stable(r_root[L]) && $stable(r_side[L])))
        else $error("stalled distance changed");

endmodule

@@ hw/rtl/las_back.sv @@
module las_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  las_pkg::t_dist i_data,
    output logic           o_ready,
    las_out_if.source      o_out
);

    localparam int W  = las_pkg::COORD_W;
    localparam int PW = las_pkg::PROD_W;
    localparam int MG = las_pkg::MAG_W;
    localparam int EW = las_pkg::EXT_W;
    localparam int TW = las_pkg::TRIG_W;
    localparam int SH = las_pkg::RND_SH;

    localparam logic [PW:0] ROUND_ADD = (PW + 1)'(1) << (SH - 1);
    localparam logic signed [EW-1:0] SAT_HI = {{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = {{(EW - W + 1){1'b1}}, {(W - 1){1'b0}}};

    logic ena, enb, enc;

    // stage a: distance times cos / sin
    logic               r_a_v;
    las_pkg::t_side     r_a_side;
    logic [PW-1:0]      r_a_px, r_a_py;
    logic [TW-1:0]      n_a_c, n_a_s;

    // stage b: round half away from zero (on the magnitude)
    logic               r_b_v;
    las_pkg::t_side     r_b_side;
    logic [MG-1:0]      r_b_mx, r_b_my;
    logic [PW:0]        n_b_rx, n_b_ry;

    // stage c: offset from start, saturate (diagonal codes; others keep rx / ry)
    logic                r_c_v;
    logic signed [W-1:0] r_c_x, r_c_y;
    logic [2:0]          r_c_code;
    logic                r_c_clip;
    logic signed [EW-1:0] n_c_vx, n_c_vy;
    logic signed [W-1:0]  n_c_x, n_c_y;
    logic                 n_c_clip, n_c_diag;

    assign enc = !r_c_v || o_out.ready;
    assign enb = !r_b_v || enc;
    assign ena = !r_a_v || enb;
    assign o_ready = ena;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (ena) r_a_v <= i_valid;
            if (enb) r_b_v <= r_a_v;
            if (enc) r_c_v <= r_b_v;
        end
    end

    always_comb begin
        n_a_c = '0;
        n_a_s = '0;
        unique case (i_data.side.code)
            las_pkg::ANG_30: begin
                n_a_c = las_pkg::TRIG_COS30;
                n_a_s = las_pkg::TRIG_HALF;
            end
            las_pkg::ANG_45: begin
                n_a_c = las_pkg::TRIG_DIAG;
                n_a_s = las_pkg::TRIG_DIAG;
            end
            las_pkg::ANG_60: begin
                n_a_c = las_pkg::TRIG_HALF;
                n_a_s = las_pkg::TRIG_COS30;
            end
            default: begin
                n_a_c = '0;
                n_a_s = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ena) begin
            r_a_side <= i_data.side;
            r_a_px   <= PW'(i_data.len) * PW'(n_a_c);
            r_a_py   <= PW'(i_data.len) * PW'(n_a_s);
        end
    end

    assign n_b_rx = (PW + 1)'(r_a_px) + ROUND_ADD;
    assign n_b_ry = (PW + 1)'(r_a_py) + ROUND_ADD;

    always_ff @(posedge i_clk) begin
        if (enb) begin
            r_b_side <= r_a_side;
            r_b_mx   <= n_b_rx[PW:SH];
            r_b_my   <= n_b_ry[PW:SH];
        end
    end

    assign n_c_vx = r_b_side.negx ? EW'(r_b_side.sx) - $signed(EW'(r_b_mx))
                                  : EW'(r_b_side.sx) + $signed(EW'(r_b_mx));
    assign n_c_vy = r_b_side.negy ? EW'(r_b_side.sy) - $signed(EW'(r_b_my))
                                  : EW'(r_b_side.sy) + $signed(EW'(r_b_my));

    assign n_c_diag = (r_b_side.code == las_pkg::ANG_30) ||
                      (r_b_side.code == las_pkg::ANG_45) ||
                      (r_b_side.code == las_pkg::ANG_60);

    always_comb begin
        n_c_x    = r_b_side.rx;
        n_c_y    = r_b_side.ry;
        n_c_clip = 1'b0;
        if (n_c_diag) begin
            if (n_c_vx > SAT_HI) begin
                n_c_x    = SAT_HI[W-1:0];
                n_c_clip = 1'b1;
            end else if (n_c_vx < SAT_LO) begin
                n_c_x    = SAT_LO[W-1:0];
                n_c_clip = 1'b1;
            end else begin
                n_c_x    = n_c_vx[W-1:0];
            end
            if (n_c_vy > SAT_HI) begin
                n_c_y    = SAT_HI[W-1:0];
                n_c_clip = 1'b1;
            end else if (n_c_vy < SAT_LO) begin
                n_c_y    = SAT_LO[W-1:0];
                n_c_clip = 1'b1;
            end else begin
                n_c_y    = n_c_vy[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enc) begin
            r_c_x    <= n_c_x;
            r_c_y    <= n_c_y;
            r_c_code <= r_b_side.code;
            r_c_clip <= n_c_clip;
        end
    end

    assign o_out.valid      = r_c_v;
    assign o_out.snapped_x  = r_c_x;
    assign o_out.snapped_y  = r_c_y;
    assign o_out.angle_code = r_c_code;
    assign o_out.clipped    = r_c_clip;

    // only diagonal results go through the saturating adders
    a_clip_diag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_v && r_c_clip) |-> (r_c_code == las_pkg::ANG_30 ||
                                 r_c_code == las_pkg::ANG_45 ||
                                 r_c_code == las_pkg::ANG_60))
        else $error("clip flagged on a non-diagonal result");

    a_round_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_v && !enc) |=> (r_b_v && $stable(r_b_mx) && $stable(r_b_my)))
        else $error("rounded magnitude lost under stall");

endmodule

@@ hw/rtl/line_angle_snap_top.sv @@
// Line angle snap: moves a line's end point to the nearest allowed angle
// around its start point (0/90 plus 45 and/or 30/60 degrees).
//
// i_in  : request with start/end points and the two snap flags; taken on a
//         cycle where valid and ready are both high.
// o_out : snapped end point, angle code and clip flag, one per request, in
//         order.
// A request passes through differences, squares and angle compares, then
// a square-root pipeline that finds the root bit by bit, then multiply,
// round and saturate.
// Throughput is one request per cycle while o_out is taken; every stage
// has its own valid bit and a stage advances whenever the one after it is
// empty or moving, so bubbles close up while the output waits.
// When the receiver stalls, the result holds on o_out and requests keep
// entering until every stage is full; then i_in.ready drops.
// Reset is synchronous and clears only the valid bits; the block takes
// requests as soon as reset is released.
module line_angle_snap_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    las_in_if.sink    i_in,
    las_out_if.source o_out
);

    logic           f_valid, f_ready;
    las_pkg::t_fwd  f_data;
    logic           d_valid, d_ready;
    las_pkg::t_dist d_data;

    las_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (f_valid),
        .o_data  (f_data),
        .i_ready (f_ready)
    );

    las_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_data  (f_data),
        .o_ready (f_ready),
        .o_valid (d_valid),
        .o_data  (d_data),
        .i_ready (d_ready)
    );

    las_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_data  (d_data),
        .o_ready (d_ready),
        .o_out   (o_out)
    );

    // back pressure only ever starts from a waiting result
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without a waiting result");

endmodule
